[design/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check on every rising edge, held off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every rising edge, live during reset too.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[design/tplw_pkg.sv]
// Shared types, codes and constants of the two-level page walk access unit.
package tplw_pkg;

   localparam int STORE_WORDS_DEFAULT = 16384;
   localparam int REQ_DATA_W          = 72;
   localparam int RSP_DATA_W          = 72;
   localparam int CSR_DATA_W          = 20;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DIR     = 2'd1,
      ST_TABLE   = 2'd2,
      ST_OUTSIDE = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CSR_PAGING   = 1'b0,
      CSR_DIR_BASE = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_XLATE,
      S_DIR_WAIT,
      S_TAB_WAIT,
      S_DATA,
      S_DATA_WAIT,
      S_RESP
   } state_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_LOAD,
      CMD_DIR_READ,
      CMD_TAB_READ,
      CMD_PA_KEEP,
      CMD_BYTE_READ,
      CMD_BYTE_DONE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic       fault_en;
      status_type fault;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   paging;
      logic   last;
      logic   va_outside;
      logic   dir_outside;
      logic   entry_absent;
      logic   tab_outside;
      logic   walk_outside;
   } dp_stat_type;

   function automatic logic [1:0] last_index(input logic [1:0] size);
      logic [1:0] r;
      case (size)
         2'd0:    r = 2'd0;
         2'd1:    r = 2'd1;
         default: r = 2'd3;
      endcase
      return r;
   endfunction

endpackage

[design/two_level_page_walk_access.sv]
// A load or an idle operation passes from acceptance through the dispatch state to the result.
// A read or write first translates each byte in turn (a directory read and a table read, or
// only a bounds check with paging off), then reads each byte from the store, writing a merged
// byte back on a write; the single store port serves directory, table and data reads in turn.
// One item at a time: the next item is accepted the cycle after the result is taken.
// Reset (synchronous, active high) clears paging and directory base; the store is not cleared.
module two_level_page_walk_access #(
   parameter int STORE_WORDS = tplw_pkg::STORE_WORDS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // address[31:0], access_size[33:32], write_data[65:34], zero fill
   input  logic [tplw_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_data[31:0], physical_address[63:32], status[65:64], zero fill
   output logic [tplw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [0:0]                      csr_index,
   input  logic [tplw_pkg::CSR_DATA_W-1:0] csr_data
);

   tplw_pkg::dp_cmd_type  cmd;
   tplw_pkg::dp_stat_type stat;

   assign csr_ready = 1'b1;

   tplw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tplw_dp #(
      .STORE_WORDS (STORE_WORDS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_index (tplw_pkg::csr_index_type'(csr_index)),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

endmodule

[design/tplw_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tplw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tplw_ctrl.sv]
// Controller state machine sequencing the walk, data and result steps.
module tplw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  tplw_pkg::dp_stat_type stat,
   output tplw_pkg::dp_cmd_type  cmd
);

   tplw_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tplw_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = tplw_pkg::CMD_NONE;
      cmd.fault_en = 1'b0;
      cmd.fault    = tplw_pkg::ST_OK;
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      unique case (state_ff)
         tplw_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = tplw_pkg::CMD_CAPTURE;
               state_in = tplw_pkg::S_DISPATCH;
            end
         end
         tplw_pkg::S_DISPATCH: begin
            unique case (stat.op) inside
               tplw_pkg::OP_LOAD: begin
                  cmd.op   = tplw_pkg::CMD_LOAD;
                  state_in = tplw_pkg::S_RESP;
               end
               tplw_pkg::OP_READ, tplw_pkg::OP_WRITE: begin
                  state_in = tplw_pkg::S_XLATE;
               end
               tplw_pkg::OP_NONE: begin
                  state_in = tplw_pkg::S_RESP;
               end
            endcase
         end
         tplw_pkg::S_XLATE: begin
            if (!stat.paging) begin
               if (stat.va_outside) begin
                  cmd.fault_en = 1'b1;
                  cmd.fault    = tplw_pkg::ST_OUTSIDE;
                  state_in     = tplw_pkg::S_RESP;
               end else begin
                  cmd.op   = tplw_pkg::CMD_PA_KEEP;
                  state_in = stat.last ? tplw_pkg::S_DATA : tplw_pkg::S_XLATE;
               end
            end else if (stat.dir_outside) begin
               cmd.fault_en = 1'b1;
               cmd.fault    = tplw_pkg::ST_OUTSIDE;
               state_in     = tplw_pkg::S_RESP;
            end else begin
               cmd.op   = tplw_pkg::CMD_DIR_READ;
               state_in = tplw_pkg::S_DIR_WAIT;
            end
         end
         tplw_pkg::S_DIR_WAIT: begin
            if (stat.entry_absent) begin
               cmd.fault_en = 1'b1;
               cmd.fault    = tplw_pkg::ST_DIR;
               state_in     = tplw_pkg::S_RESP;
            end else if (stat.tab_outside) begin
               cmd.fault_en = 1'b1;
               cmd.fault    = tplw_pkg::ST_OUTSIDE;
               state_in     = tplw_pkg::S_RESP;
            end else begin
               cmd.op   = tplw_pkg::CMD_TAB_READ;
               state_in = tplw_pkg::S_TAB_WAIT;
            end
         end
         tplw_pkg::S_TAB_WAIT: begin
            if (stat.entry_absent) begin
               cmd.fault_en = 1'b1;
               cmd.fault    = tplw_pkg::ST_TABLE;
               state_in     = tplw_pkg::S_RESP;
            end else if (stat.walk_outside) begin
               cmd.fault_en = 1'b1;
               cmd.fault    = tplw_pkg::ST_OUTSIDE;
               state_in     = tplw_pkg::S_RESP;
            end else begin
               cmd.op   = tplw_pkg::CMD_PA_KEEP;
               state_in = stat.last ? tplw_pkg::S_DATA : tplw_pkg::S_XLATE;
            end
         end
         tplw_pkg::S_DATA: begin
            cmd.op   = tplw_pkg::CMD_BYTE_READ;
            state_in = tplw_pkg::S_DATA_WAIT;
         end
         tplw_pkg::S_DATA_WAIT: begin
            cmd.op   = tplw_pkg::CMD_BYTE_DONE;
            state_in = stat.last ? tplw_pkg::S_RESP : tplw_pkg::S_DATA;
         end
         tplw_pkg::S_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = tplw_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tplw_pkg::S_IDLE;
         end
      endcase
   end

endmodule

[design/tplw_dp.sv]
// Datapath: request and config registers, walk address logic, store and result.
module tplw_dp #(
   parameter int STORE_WORDS = tplw_pkg::STORE_WORDS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [tplw_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                      req_tuser,
   input  logic                            csr_valid,
   input  tplw_pkg::csr_index_type         csr_index,
   input  logic [tplw_pkg::CSR_DATA_W-1:0] csr_data,
   input  tplw_pkg::dp_cmd_type            cmd,
   output tplw_pkg::dp_stat_type           stat,
   output logic [tplw_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int          AW          = $clog2(STORE_WORDS);
   localparam logic [32:0] STORE_LIMIT = 33'(STORE_WORDS);
   localparam logic [32:0] STORE_BYTES = 33'(STORE_WORDS) << 2;

   logic                paging_ff, paging_in;
   logic [19:0]         dir_base_ff, dir_base_in;
   tplw_pkg::op_type    op_ff, op_in;
   logic [31:0]         addr_ff, addr_in;
   logic [1:0]          size_ff, size_in;
   logic [31:0]         wdata_ff, wdata_in;
   logic [1:0]          idx_ff, idx_in;
   logic [31:0]         pa_ff [4];
   logic [31:0]         pa_in [4];
   logic [31:0]         res_rdata_ff, res_rdata_in;
   logic [31:0]         res_pa_ff, res_pa_in;
   tplw_pkg::status_type res_status_ff, res_status_in;

   logic [31:0]   va, dir_addr, tab_addr, walk_pa, cur_pa, merged;
   logic [4:0]    sh;
   logic [7:0]    rd_byte, wr_byte;
   logic          last;
   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [31:0]   ram_wr_data, ram_rd_data;

   assign va       = addr_ff + 32'(idx_ff);
   assign dir_addr = {dir_base_ff, va[31:22], 2'b00};
   assign tab_addr = {ram_rd_data[31:12], va[21:12], 2'b00};
   assign walk_pa  = {ram_rd_data[31:12], va[11:0]};
   assign cur_pa   = pa_ff[idx_ff];
   assign sh       = {cur_pa[1:0], 3'b000};
   assign rd_byte  = 8'(ram_rd_data >> sh);
   assign wr_byte  = 8'(wdata_ff >> {idx_ff, 3'b000});
   assign merged   = (ram_rd_data & ~(32'hFF << sh)) | (32'(wr_byte) << sh);
   assign last     = (idx_ff == tplw_pkg::last_index(size_ff));

   assign stat.op           = op_ff;
   assign stat.paging       = paging_ff;
   assign stat.last         = last;
   assign stat.va_outside   = (33'(va) >= STORE_BYTES);
   assign stat.dir_outside  = (33'(dir_addr) >= STORE_BYTES);
   assign stat.entry_absent = !ram_rd_data[0];
   assign stat.tab_outside  = (33'(tab_addr) >= STORE_BYTES);
   assign stat.walk_outside = (33'(walk_pa) >= STORE_BYTES);

   assign rsp_tdata = {6'b000000, res_status_ff, res_pa_ff, res_rdata_ff};

   always_comb begin
      paging_in     = paging_ff;
      dir_base_in   = dir_base_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      size_in       = size_ff;
      wdata_in      = wdata_ff;
      idx_in        = idx_ff;
      pa_in         = pa_ff;
      res_rdata_in  = res_rdata_ff;
      res_pa_in     = res_pa_ff;
      res_status_in = res_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cur_pa[AW+1:2];
      ram_wr_data   = merged;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = cur_pa[AW+1:2];

      if (csr_valid) begin
         unique case (csr_index)
            tplw_pkg::CSR_PAGING:   paging_in   = csr_data[0];
            tplw_pkg::CSR_DIR_BASE: dir_base_in = csr_data;
            default:                paging_in   = paging_ff;
         endcase
      end

      if (cmd.fault_en) begin
         res_rdata_in  = '0;
         res_pa_in     = '0;
         res_status_in = cmd.fault;
      end

      unique case (cmd.op)
         tplw_pkg::CMD_NONE: begin
            idx_in = idx_ff;
         end
         tplw_pkg::CMD_CAPTURE: begin
            op_in         = tplw_pkg::op_type'(req_tuser);
            addr_in       = req_tdata[31:0];
            size_in       = req_tdata[33:32];
            wdata_in      = req_tdata[65:34];
            idx_in        = 2'd0;
            res_rdata_in  = '0;
            res_pa_in     = '0;
            res_status_in = tplw_pkg::ST_OK;
         end
         tplw_pkg::CMD_LOAD: begin
            res_pa_in   = addr_ff;
            ram_wr_addr = addr_ff[AW-1:0];
            ram_wr_data = wdata_ff;
            if (33'(addr_ff) < STORE_LIMIT) begin
               ram_wr_en = 1'b1;
            end else begin
               res_status_in = tplw_pkg::ST_OUTSIDE;
            end
         end
         tplw_pkg::CMD_DIR_READ: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = dir_addr[AW+1:2];
         end
         tplw_pkg::CMD_TAB_READ: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = tab_addr[AW+1:2];
         end
         tplw_pkg::CMD_PA_KEEP: begin
            pa_in[idx_ff] = paging_ff ? walk_pa : va;
            idx_in        = last ? 2'd0 : idx_ff + 2'd1;
         end
         tplw_pkg::CMD_BYTE_READ: begin
            ram_rd_en = 1'b1;
         end
         tplw_pkg::CMD_BYTE_DONE: begin
            if (op_ff == tplw_pkg::OP_WRITE) begin
               ram_wr_en = 1'b1;
            end else begin
               res_rdata_in = res_rdata_ff | (32'(rd_byte) << {idx_ff, 3'b000});
            end
            res_pa_in = pa_ff[0];
            idx_in    = last ? 2'd0 : idx_ff + 2'd1;
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         paging_ff   <= 1'b0;
         dir_base_ff <= '0;
      end else begin
         paging_ff   <= paging_in;
         dir_base_ff <= dir_base_in;
      end
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      size_ff       <= size_in;
      wdata_ff      <= wdata_in;
      idx_ff        <= idx_in;
      pa_ff         <= pa_in;
      res_rdata_ff  <= res_rdata_in;
      res_pa_ff     <= res_pa_in;
      res_status_ff <= res_status_in;
   end

   tplw_ram #(
      .WIDTH (32),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

[design/tplw_checker.sv]
// Port-level checker for the page walk access unit and its bind.
`include "assert_macros.svh"

module tplw_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tplw_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   `ASSERT_CLK_ALWAYS(a_reset_no_rsp, clock, reset |=> !rsp_tvalid, "result valid after reset")

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled item changed")

   `ASSERT_CLK(a_one_in_flight, clock, reset, !(req_tready && rsp_tvalid), "input taken while a result waits")

   `ASSERT_CLK(a_no_instant_rsp, clock, reset, req_tvalid && req_tready |=> !rsp_tvalid, "result shown in the cycle after acceptance")

   `ASSERT_CLK(a_fault_zero, clock, reset, rsp_tvalid && (rsp_tdata[65:64] == tplw_pkg::ST_DIR || rsp_tdata[65:64] == tplw_pkg::ST_TABLE) |-> rsp_tdata[63:0] == 64'd0, "walk fault with nonzero data")

endmodule

bind two_level_page_walk_access tplw_checker u_checker (.*);
